/* design/woas_pkg.sv */
// Shared types and constants for the windowed overlap-add synthesis unit.
// Used by the top level, the result queue and the port checker; no dependencies.
package woas_pkg;

   localparam int MAX_FRAME_DEFAULT = 512;

   localparam int COEF_INDEX_W = 9;
   localparam int COEF_W       = 16;
   localparam int SAMPLE_W     = 32;
   localparam int OUT_W        = 16;
   localparam int PROD_W       = COEF_W + SAMPLE_W;
   localparam int PROD_SHIFT   = 21;

   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_LENGTH   = 2'd1;

   localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = 10'd512;
   localparam logic [CFG_W-1:0] HOP_LENGTH_RESET   = 10'd256;

   localparam logic OP_COEF_WRITE = 1'b0;
   localparam logic OP_SAMPLE     = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [OUT_W-1:0]    OUT_MAX = 16'sh7FFF;
   localparam logic signed [OUT_W-1:0]    OUT_MIN = 16'sh8000;

   // Result queue depth; must be a power of two.
   localparam int RSP_FIFO_DEPTH = 4;

   typedef struct packed {
      logic                              opcode;
      logic [COEF_INDEX_W-1:0]           coef_index;
      logic signed [COEF_W-1:0]          coef_value;
      logic signed [SAMPLE_W-1:0]        frame_sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_sample;
      logic                    hop_done;
   } rsp_type;

endpackage

/* design/woas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module woas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/woas_rsp_fifo.sv */
// Small result queue that decouples the accumulate pipeline from the receiver.
// Depends on woas_pkg for the result transaction type.
module woas_rsp_fifo #(
   parameter int DEPTH = woas_pkg::RSP_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  woas_pkg::rsp_type          push_data,
   input  logic                       pop,
   output woas_pkg::rsp_type          pop_data,
   output logic                       not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   woas_pkg::rsp_type mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

/* design/windowed_overlap_add_synthesis_unit.sv */
// Windowed overlap-add synthesis unit: top level.
// Depends on woas_pkg, woas_ram (window and overlap stores) and woas_rsp_fifo.
//
// Usage:
//  - req_ channel: one transaction per cycle while ready. Opcode OP_COEF_WRITE loads
//    a window coefficient; opcode OP_SAMPLE delivers the next frame sample in frame order.
//  - rsp_ channel: one transaction per finished output sample (the first hop
//    positions of each frame); hop_done marks the last sample of the hop.
//  - csr_ channel: index 0 writes frame_length, index 1 writes hop_length. Any
//    such write clears the overlap accumulator and restarts the frame.
// Throughput: one request per cycle, sustained, as long as the receiver keeps
// up and no clearing pass runs. A result reaches rsp_ by way of the store read
// at the accepting edge, the multiply stage, then the accumulate stage into the
// result queue.
// Reset and every length write start a clearing pass over all MAX_FRAME slots
// of the overlap store, one slot per cycle; req_ready stays low until it ends.
// Window coefficients are not cleared and must be loaded before use.
// Receiver stall: results wait in a four-entry queue; req_ready drops once the
// queue plus results still in the pipeline would fill it, so nothing is lost.
module windowed_overlap_add_synthesis_unit #(
   parameter int MAX_FRAME = woas_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  woas_pkg::req_type                     req_payload,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output woas_pkg::rsp_type                     rsp_payload,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [woas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [woas_pkg::CFG_W-1:0]            csr_wdata
);

   // Address width of the stores, width of a length up to MAX_FRAME, and
   // comparison widths wide enough for both the config fields and MAX_FRAME.
   localparam int AW = $clog2(MAX_FRAME);
   localparam int NW = $clog2(MAX_FRAME + 1);
   localparam int LW = (NW > woas_pkg::CFG_W) ? NW : woas_pkg::CFG_W;
   localparam int IW = ((AW + 1) > woas_pkg::COEF_INDEX_W) ? (AW + 1) :
                       woas_pkg::COEF_INDEX_W;
   localparam int SW = woas_pkg::SAMPLE_W;
   localparam int PW = woas_pkg::PROD_W;
   localparam int HW = PW - woas_pkg::PROD_SHIFT;
   localparam int FD = woas_pkg::RSP_FIFO_DEPTH;
   localparam int FCW = $clog2(FD + 1);
   localparam int CRW = $clog2(FD + 3);

   // ---------------------------------------------------------------------
   // Configuration registers and clearing pass
   // ---------------------------------------------------------------------
   logic [woas_pkg::CFG_W-1:0] frame_length_ff, hop_length_ff;
   logic                       clear_busy_ff;
   logic [AW-1:0]              clear_addr_ff;
   logic                       csr_fire, len_write;

   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;
   // Indexes beyond the register list are accepted and dropped.
   assign len_write = csr_fire && ((csr_index == woas_pkg::CSR_FRAME_LENGTH) ||
                                   (csr_index == woas_pkg::CSR_HOP_LENGTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= woas_pkg::FRAME_LENGTH_RESET;
         hop_length_ff   <= woas_pkg::HOP_LENGTH_RESET;
         clear_busy_ff   <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         if (csr_fire && (csr_index == woas_pkg::CSR_FRAME_LENGTH)) begin
            frame_length_ff <= csr_wdata;
         end
         if (csr_fire && (csr_index == woas_pkg::CSR_HOP_LENGTH)) begin
            hop_length_ff <= csr_wdata;
         end
         if (len_write) begin
            // Restart the sweep from slot zero.
            clear_busy_ff <= 1'b1;
            clear_addr_ff <= '0;
         end else if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(MAX_FRAME - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
      end
   end

   // Effective frame length in [1, MAX_FRAME], hop in [1, frame length].
   logic [LW-1:0] frame_ext, hop_ext;
   logic [NW-1:0] eff_frame, eff_hop;

   always_comb begin
      frame_ext = LW'(frame_length_ff);
      hop_ext   = LW'(hop_length_ff);
      if (frame_ext == '0) begin
         eff_frame = NW'(1);
      end else if (frame_ext > LW'(MAX_FRAME)) begin
         eff_frame = NW'(MAX_FRAME);
      end else begin
         eff_frame = NW'(frame_ext);
      end
      if (hop_ext == '0) begin
         eff_hop = NW'(1);
      end else if (hop_ext > LW'(eff_frame)) begin
         eff_hop = eff_frame;
      end else begin
         eff_hop = NW'(hop_ext);
      end
   end

   // ---------------------------------------------------------------------
   // Request acceptance and frame bookkeeping
   // ---------------------------------------------------------------------
   logic             s1_valid_ff, s1_emit_ff;
   logic             s2_valid_ff, s2_emit_ff;
   logic [FCW-1:0]   fifo_count;
   logic [CRW-1:0]   credit_used;
   logic             req_fire, sample_fire, coef_fire;

   // Reserve a queue entry for every result already in the pipeline.
   assign credit_used = CRW'(fifo_count) + CRW'(s1_valid_ff && s1_emit_ff) +
                        CRW'(s2_valid_ff && s2_emit_ff);
   assign req_ready   = !reset && !clear_busy_ff && (credit_used < CRW'(FD));
   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_payload.opcode == woas_pkg::OP_SAMPLE);
   assign coef_fire   = req_fire && (req_payload.opcode == woas_pkg::OP_COEF_WRITE) &&
                        (IW'(req_payload.coef_index) < IW'(MAX_FRAME));

   logic [AW-1:0] frame_pos_ff, frame_pos_in;
   logic [AW-1:0] ring_base_ff, ring_base_in;
   logic [AW:0]   slot_sum, pos_inc, base_sum;
   logic [AW-1:0] slot;
   logic          emit, hop_last;

   always_comb begin
      slot_sum = (AW+1)'(ring_base_ff) + (AW+1)'(frame_pos_ff);
      if (slot_sum >= (AW+1)'(eff_frame)) begin
         slot = AW'(slot_sum - (AW+1)'(eff_frame));
      end else begin
         slot = AW'(slot_sum);
      end
      emit     = (AW+1)'(frame_pos_ff) < (AW+1)'(eff_hop);
      hop_last = (AW+1)'(frame_pos_ff) == ((AW+1)'(eff_hop) - (AW+1)'(1));

      pos_inc      = (AW+1)'(frame_pos_ff) + (AW+1)'(1);
      base_sum     = (AW+1)'(ring_base_ff) + (AW+1)'(eff_hop);
      frame_pos_in = frame_pos_ff;
      ring_base_in = ring_base_ff;
      if (sample_fire) begin
         if (pos_inc >= (AW+1)'(eff_frame)) begin
            // Frame complete: advance the ring by one hop.
            frame_pos_in = '0;
            if (base_sum >= (AW+1)'(eff_frame)) begin
               ring_base_in = AW'(base_sum - (AW+1)'(eff_frame));
            end else begin
               ring_base_in = AW'(base_sum);
            end
         end else begin
            frame_pos_in = AW'(pos_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || len_write) begin
         frame_pos_ff <= '0;
         ring_base_ff <= '0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         ring_base_ff <= ring_base_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stores: window read at the frame position, overlap read at the slot
   // ---------------------------------------------------------------------
   logic signed [woas_pkg::COEF_W-1:0] win_rd;
   logic signed [SW-1:0]               ovl_rd;
   logic                               ovl_we;
   logic [AW-1:0]                      ovl_waddr;
   logic signed [SW-1:0]               ovl_wdata;

   woas_ram #(
      .WIDTH (woas_pkg::COEF_W),
      .DEPTH (MAX_FRAME)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (coef_fire),
      .wr_addr (AW'(req_payload.coef_index)),
      .wr_data (req_payload.coef_value),
      .rd_addr (frame_pos_ff),
      .rd_data (win_rd)
   );

   woas_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_FRAME)
   ) u_overlap_ram (
      .clock   (clock),
      .wr_en   (ovl_we),
      .wr_addr (ovl_waddr),
      .wr_data (ovl_wdata),
      .rd_addr (slot),
      .rd_data (ovl_rd)
   );

   // ---------------------------------------------------------------------
   // Stage 1: multiply coefficient by sample
   // ---------------------------------------------------------------------
   logic                 s1_last_ff;
   logic [AW-1:0]        s1_slot_ff;
   logic signed [SW-1:0] s1_sample_ff;
   logic signed [PW-1:0] product;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= sample_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff   <= emit;
      s1_last_ff   <= hop_last;
      s1_slot_ff   <= slot;
      s1_sample_ff <= req_payload.frame_sample;
   end

   assign product = PW'(win_rd) * PW'(s1_sample_ff);

   // Last overlap write, held in a register to cover the read-before-write gap.
   logic                 wb_valid_ff;
   logic [AW-1:0]        wb_addr_ff;
   logic signed [SW-1:0] wb_data_ff;

   // ---------------------------------------------------------------------
   // Stage 2: accumulate, saturate, write back, queue result
   // ---------------------------------------------------------------------
   logic                 s2_last_ff;
   logic [AW-1:0]        s2_slot_ff;
   logic signed [PW-1:0] s2_prod_ff;
   logic signed [SW-1:0] s2_ovl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_emit_ff <= s1_emit_ff;
      s2_last_ff <= s1_last_ff;
      s2_slot_ff <= s1_slot_ff;
      s2_prod_ff <= product;
      // Take the value written while the read was in flight.
      if (wb_valid_ff && (wb_addr_ff == s1_slot_ff)) begin
         s2_ovl_ff <= wb_data_ff;
      end else begin
         s2_ovl_ff <= ovl_rd;
      end
   end

   logic signed [SW-1:0]               ovl_eff, acc;
   logic signed [HW-1:0]               prod_sh;
   logic signed [SW:0]                 acc_sum;
   logic signed [woas_pkg::OUT_W-1:0]  out_sat;
   woas_pkg::rsp_type                  rsp_next;

   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == s2_slot_ff)) begin
         ovl_eff = wb_data_ff;
      end else begin
         ovl_eff = s2_ovl_ff;
      end
      // Arithmetic shift toward minus infinity: drop the low product bits.
      prod_sh = s2_prod_ff[PW-1:woas_pkg::PROD_SHIFT];
      acc_sum = (SW+1)'(ovl_eff) + (SW+1)'(prod_sh);
      if (acc_sum[SW] != acc_sum[SW-1]) begin
         acc = acc_sum[SW] ? woas_pkg::ACC_MIN : woas_pkg::ACC_MAX;
      end else begin
         acc = acc_sum[SW-1:0];
      end
      if (acc > SW'(woas_pkg::OUT_MAX)) begin
         out_sat = woas_pkg::OUT_MAX;
      end else if (acc < SW'(woas_pkg::OUT_MIN)) begin
         out_sat = woas_pkg::OUT_MIN;
      end else begin
         out_sat = acc[woas_pkg::OUT_W-1:0];
      end
      rsp_next.out_sample = out_sat;
      rsp_next.hop_done   = s2_last_ff;

      // The clearing pass owns the write port; finished slots drop to zero.
      ovl_we    = clear_busy_ff || s2_valid_ff;
      ovl_waddr = clear_busy_ff ? clear_addr_ff : s2_slot_ff;
      if (clear_busy_ff || s2_emit_ff) begin
         ovl_wdata = '0;
      end else begin
         ovl_wdata = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= ovl_we;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= ovl_waddr;
      wb_data_ff <= ovl_wdata;
   end

   woas_rsp_fifo #(
      .DEPTH (FD)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff && s2_emit_ff && !clear_busy_ff),
      .push_data (rsp_next),
      .pop       (rsp_ready),
      .pop_data  (rsp_payload),
      .not_empty (rsp_valid),
      .count     (fifo_count)
   );

endmodule

/* design/woas_checker.sv */
// Port-level checker for the overlap-add synthesis unit, bound to the top level.
// Depends on woas_pkg for transaction types and register indexes.
module woas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input woas_pkg::rsp_type                rsp_payload,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [woas_pkg::CSR_INDEX_W-1:0] csr_index
);

   // Reset starts the clearing pass: no request is taken right after it.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted right after reset");

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A length write restarts the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       ((csr_index == woas_pkg::CSR_FRAME_LENGTH) ||
        (csr_index == woas_pkg::CSR_HOP_LENGTH))) |=> !req_ready)
      else $error("request accepted while the accumulator is being cleared");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result dropped or changed");

endmodule

bind windowed_overlap_add_synthesis_unit woas_checker u_woas_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_index   (csr_index)
);
